FILE: design/mlbt_pkg.sv
// Shared types, constants and helpers of the markup byte tokenizer.
package mlbt_pkg;

  localparam int unsigned LineBits    = 16;
  localparam int unsigned LineOutBits = 16;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned PtrBits     = $clog2(FifoDepth);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChEqual  = 8'h3D;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChUscore = 8'h5F;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_FRAC,
    MODE_STR,
    MODE_CMT
  } mode_e;

  typedef enum logic [3:0] {
    KIND_EOF,
    KIND_EQUAL,
    KIND_COLON,
    KIND_LBRACKET,
    KIND_RBRACKET,
    KIND_COMMA,
    KIND_STRING,
    KIND_IDENT,
    KIND_END,
    KIND_FALSE,
    KIND_TRUE,
    KIND_UINT,
    KIND_SINT,
    KIND_FLOAT
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_BAD_CHAR,
    ERR_UNTERM_STR,
    ERR_MULTILINE_STR
  } err_e;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             text_byte;
    logic                   text_valid;
    logic                   token_done;
    logic [LineOutBits-1:0] line_no;
    err_e                   error_code;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic valid0;
    logic valid1;
    res_t res0;
    res_t res1;
  } step_out_t;

  // The line counter is reported clipped to the width of the result field.
  function automatic logic [LineOutBits-1:0] line_report(logic [LineBits-1:0] v);
    logic [LineBits+LineOutBits-1:0] w;
    w = {{LineOutBits{1'b0}}, v};
    if (w > (LineBits + LineOutBits)'({LineOutBits{1'b1}})) begin
      return '1;
    end
    return w[LineOutBits-1:0];
  endfunction

endpackage

FILE: design/mlbt_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
module mlbt_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push0_i,
  input  logic             push1_i,
  input  mlbt_pkg::res_t   res0_i,
  input  mlbt_pkg::res_t   res1_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output mlbt_pkg::res_t   res_o
);
  import mlbt_pkg::*;

  res_t               mem_q [FifoDepth];
  logic [PtrBits-1:0] wr_q, wr_d;
  logic [PtrBits-1:0] rd_q, rd_d;
  logic [PtrBits:0]   cnt_q, cnt_d;
  logic               pop;

  assign pop     = (cnt_q != '0) && ready_i;
  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rd_q];
  // Room for the two results that one byte may cause.
  assign space_o = (cnt_q <= (PtrBits + 1)'(FifoDepth - 2));

  always_comb begin
    wr_d  = wr_q + PtrBits'(push0_i) + PtrBits'(push1_i);
    rd_d  = rd_q + PtrBits'(pop);
    cnt_d = cnt_q + (PtrBits + 1)'(push0_i) + (PtrBits + 1)'(push1_i) - (PtrBits + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push1_i) begin
      mem_q[wr_q + PtrBits'(1)] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: design/mlbt_lex_step.sv
// Lexer state and the per-byte rule that yields up to two results.
module mlbt_lex_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           char_i,
  output mlbt_pkg::step_out_t  step_o
);
  import mlbt_pkg::*;

  mode_e               mode_q, mode_d;
  logic                minus_q, minus_d;
  logic [2:0]          hits_q, hits_d;
  logic [2:0]          len_q, len_d;
  logic [LineBits-1:0] line_q, line_d;
  logic                halted_q, halted_d;

  logic  line_bump;
  logic  first_v, idle_run, idle_v;
  logic  punct_hit;
  kind_e punct_kind;
  res_t  base_r, first_r, idle_r;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUscore;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == ChNl || c == ChTab || c == ChFf || c == ChCr || c == ChSpace;
  endfunction

  // Bit 0 end, bit 1 False, bit 2 True: set where c matches at this position.
  function automatic logic [2:0] kw_match(logic [2:0] len, logic [7:0] c);
    logic [2:0] m;
    m[0] = (len == 3'd0 && c == "e") || (len == 3'd1 && c == "n") ||
           (len == 3'd2 && c == "d");
    m[1] = (len == 3'd0 && c == "F") || (len == 3'd1 && c == "a") ||
           (len == 3'd2 && c == "l") || (len == 3'd3 && c == "s") ||
           (len == 3'd4 && c == "e");
    m[2] = (len == 3'd0 && c == "T") || (len == 3'd1 && c == "r") ||
           (len == 3'd2 && c == "u") || (len == 3'd3 && c == "e");
    return m;
  endfunction

  function automatic kind_e ident_kind(logic [2:0] hits, logic [2:0] len);
    if (hits[0] && len == 3'd3) begin
      return KIND_END;
    end
    if (hits[1] && len == 3'd5) begin
      return KIND_FALSE;
    end
    if (hits[2] && len == 3'd4) begin
      return KIND_TRUE;
    end
    return KIND_IDENT;
  endfunction

  always_comb begin
    punct_hit  = 1'b1;
    punct_kind = KIND_EOF;
    case (char_i)
      ChEqual:  punct_kind = KIND_EQUAL;
      ChColon:  punct_kind = KIND_COLON;
      ChLBrack: punct_kind = KIND_LBRACKET;
      ChRBrack: punct_kind = KIND_RBRACKET;
      ChComma:  punct_kind = KIND_COMMA;
      default:  punct_hit = 1'b0;
    endcase
  end

  always_comb begin
    base_r         = '0;
    base_r.line_no = line_report(line_q);

    mode_d    = mode_q;
    minus_d   = minus_q;
    hits_d    = hits_q;
    len_d     = len_q;
    halted_d  = halted_q;
    line_bump = 1'b0;
    first_v   = 1'b0;
    first_r   = base_r;
    idle_run  = 1'b0;
    idle_v    = 1'b0;
    idle_r    = base_r;

    if (!halted_q) begin
      unique case (mode_q)
        MODE_IDENT: begin
          if (is_letter(char_i)) begin
            hits_d             = hits_q & kw_match(len_q, char_i);
            len_d              = (len_q == 3'd7) ? len_q : len_q + 3'd1;
            first_v            = 1'b1;
            first_r.text_byte  = char_i;
            first_r.text_valid = 1'b1;
          end else begin
            first_v            = 1'b1;
            first_r.kind       = ident_kind(hits_q, len_q);
            first_r.token_done = 1'b1;
            idle_run           = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(char_i) || char_i == ChDot) begin
            if (char_i == ChDot) begin
              mode_d = MODE_FRAC;
            end
            first_v            = 1'b1;
            first_r.text_byte  = char_i;
            first_r.text_valid = 1'b1;
          end else begin
            first_v            = 1'b1;
            first_r.kind       = minus_q ? KIND_SINT : KIND_UINT;
            first_r.token_done = 1'b1;
            minus_d            = 1'b0;
            idle_run           = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(char_i)) begin
            first_v            = 1'b1;
            first_r.text_byte  = char_i;
            first_r.text_valid = 1'b1;
          end else begin
            first_v            = 1'b1;
            first_r.kind       = KIND_FLOAT;
            first_r.token_done = 1'b1;
            minus_d            = 1'b0;
            idle_run           = 1'b1;
          end
        end
        MODE_STR: begin
          first_v = 1'b1;
          if (char_i == ChQuote) begin
            first_r.kind       = KIND_STRING;
            first_r.token_done = 1'b1;
            mode_d             = MODE_IDLE;
          end else if (char_i == ChNul) begin
            first_r.error_code = ERR_UNTERM_STR;
            halted_d           = 1'b1;
            mode_d             = MODE_IDLE;
          end else if (char_i == ChNl) begin
            first_r.error_code = ERR_MULTILINE_STR;
            halted_d           = 1'b1;
            mode_d             = MODE_IDLE;
          end else begin
            first_r.text_byte  = char_i;
            first_r.text_valid = 1'b1;
          end
        end
        MODE_CMT: begin
          if (char_i == ChNl) begin
            line_bump = 1'b1;
            mode_d    = MODE_IDLE;
          end else if (char_i == ChNul) begin
            idle_run = 1'b1;
          end
        end
        default: begin
          idle_run = 1'b1;
        end
      endcase

      // A byte that ends an identifier or a number is lexed again from idle.
      if (idle_run) begin
        mode_d = MODE_IDLE;
        if (is_space(char_i)) begin
          line_bump = (char_i == ChNl);
        end else if (char_i == ChNul) begin
          idle_v            = 1'b1;
          idle_r.kind       = KIND_EOF;
          idle_r.token_done = 1'b1;
        end else if (is_digit(char_i) || char_i == ChMinus) begin
          mode_d            = MODE_INT;
          minus_d           = (char_i == ChMinus);
          idle_v            = 1'b1;
          idle_r.text_byte  = char_i;
          idle_r.text_valid = 1'b1;
        end else if (is_letter(char_i)) begin
          mode_d            = MODE_IDENT;
          hits_d            = kw_match(3'd0, char_i);
          len_d             = 3'd1;
          idle_v            = 1'b1;
          idle_r.text_byte  = char_i;
          idle_r.text_valid = 1'b1;
        end else if (char_i == ChHash) begin
          mode_d = MODE_CMT;
        end else if (char_i == ChQuote) begin
          mode_d = MODE_STR;
        end else if (punct_hit) begin
          idle_v            = 1'b1;
          idle_r.kind       = punct_kind;
          idle_r.text_byte  = char_i;
          idle_r.text_valid = 1'b1;
          idle_r.token_done = 1'b1;
        end else begin
          idle_v            = 1'b1;
          idle_r.error_code = ERR_BAD_CHAR;
          halted_d          = 1'b1;
        end
      end
    end

    line_d = (line_bump && line_q != '1) ? line_q + LineBits'(1) : line_q;

    step_o.valid0    = first_v | idle_v;
    step_o.valid1    = first_v & idle_v;
    step_o.res0      = first_v ? first_r : idle_r;
    step_o.res0.last = !(first_v && idle_v);
    step_o.res1      = idle_r;
    step_o.res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      minus_q  <= 1'b0;
      hits_q   <= 3'b111;
      len_q    <= 3'd0;
      line_q   <= '0;
      halted_q <= 1'b0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      minus_q  <= minus_d;
      hits_q   <= hits_d;
      len_q    <= len_d;
      line_q   <= line_d;
      halted_q <= halted_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !step_o.valid0)
    else $error("halted lexer produced a result");

  a_error_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_o.valid0 && step_o.res0.error_code != ERR_NONE) |-> !step_o.valid1)
    else $error("error result followed by a second result");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && step_o.valid0 && step_o.res0.error_code != ERR_NONE) |=> halted_q)
    else $error("error beat did not halt the lexer");

  a_ident_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDENT) |-> (len_q != 3'd0))
    else $error("identifier mode with empty identifier");
`endif

endmodule

FILE: design/markup_lexer_byte_tokenizer.sv
// Top level of the markup byte tokenizer: lexer step and result queue.
//
//  channel  | dir | tdata                                  | tuser  | tlast
//  s_axis   | in  | [7:0] char_in                          | -      | -
//  m_axis   | out | text_byte, text_valid, token_done,     | kind   | last_of_run
//           |     | line_no, error_code                    |        |
//
// One source byte is taken per cycle while s_axis_tready is high; each byte is
// lexed in the cycle it is accepted and yields zero, one or two result beats.
// The four-entry result queue sets the rate: s_axis_tready is high while the
// queue has room for two results, so with m_axis_tready high, one-beat bytes stream
// at one per cycle and two-beat bytes are drained at one beat per cycle.
// Reset clears the lexer state, the line counter, the halt flag and the queue.
// A stalled m_axis holds its beat; s_axis stalls once the queue lacks room for two results.
module markup_lexer_byte_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] text_byte, [8] text_valid, [9] token_done, [25:10] line_no,
  // [27:26] error_code, [31:28] zero
  output logic [31:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [3:0] kind
  output logic        m_axis_tlast    // last_of_run
);
  import mlbt_pkg::*;

  logic      fire;
  logic      space;
  step_out_t step;
  res_t      head;

  assign s_axis_tready = space;
  assign fire          = s_axis_tvalid && space;

  mlbt_lex_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (s_axis_tdata),
    .step_o (step)
  );

  mlbt_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (fire && step.valid0),
    .push1_i (fire && step.valid1),
    .res0_i  (step.res0),
    .res1_i  (step.res1),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (head)
  );

  assign m_axis_tdata = {4'b0000, head.error_code, head.line_no, head.token_done,
                         head.text_valid, head.text_byte};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the markup byte tokenizer stream block.
`timescale 1ns / 1ps

module tb_top;
  import mlbt_pkg::*;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned HoldAfter   = 300;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomBytes = 850;

  typedef struct {
    kind_e       kind;
    logic [7:0]  text_byte;
    logic        text_valid;
    logic        token_done;
    logic [15:0] line_no;
    err_e        error_code;
    logic        last;
  } token_beat_t;

  // Tracks the lexer state and holds the beats that the accepted bytes must produce.
  class token_scoreboard;
    token_beat_t expected_beats[$];
    token_beat_t step_beats[$];
    int unsigned bytes_taken;
    int unsigned mismatches;
    mode_e       mode;
    logic        minus_seen;
    logic [39:0] ident_head;
    int unsigned ident_len;
    logic [15:0] line_cnt;
    logic        halted;

    function new();
      bytes_taken = 0;
      mismatches  = 0;
      mode        = MODE_IDLE;
      minus_seen  = 1'b0;
      ident_head  = '0;
      ident_len   = 0;
      line_cnt    = '0;
      halted      = 1'b0;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUscore;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void emit(kind_e k, logic [7:0] b, logic tv, logic dn, err_e e);
      token_beat_t t;
      t.kind       = k;
      t.text_byte  = b;
      t.text_valid = tv;
      t.token_done = dn;
      t.line_no    = line_cnt;
      t.error_code = e;
      t.last       = 1'b0;
      step_beats.insert(step_beats.size(), t);
    endfunction

    function void fault(err_e e);
      emit(KIND_EOF, 8'h00, 1'b0, 1'b0, e);
      halted = 1'b1;
      mode   = MODE_IDLE;
    endfunction

    // Only the first five characters matter: no keyword is longer.
    function void grow_ident(logic [7:0] c);
      if (ident_len < 5) ident_head = {ident_head[31:0], c};
      if (ident_len < 7) ident_len++;
    endfunction

    function void bump_line();
      if (line_cnt != '1) line_cnt++;
    endfunction

    function void lex_idle(logic [7:0] c);
      kind_e pk;
      bit    punct;
      mode  = MODE_IDLE;
      punct = 1'b1;
      if (c == ChSpace || c == ChTab || c == ChNl || c == ChFf || c == ChCr) begin
        if (c == ChNl) bump_line();
      end else if (c == ChNul) begin
        emit(KIND_EOF, 8'h00, 1'b0, 1'b1, ERR_NONE);
      end else if (is_digit(c) || c == ChMinus) begin
        mode       = MODE_INT;
        minus_seen = (c == ChMinus);
        emit(KIND_EOF, c, 1'b1, 1'b0, ERR_NONE);
      end else if (is_letter(c)) begin
        mode       = MODE_IDENT;
        ident_head = '0;
        ident_len  = 0;
        grow_ident(c);
        emit(KIND_EOF, c, 1'b1, 1'b0, ERR_NONE);
      end else if (c == ChHash) begin
        mode = MODE_CMT;
      end else if (c == ChQuote) begin
        mode = MODE_STR;
      end else begin
        case (c)
          ChEqual:  pk = KIND_EQUAL;
          ChColon:  pk = KIND_COLON;
          ChLBrack: pk = KIND_LBRACKET;
          ChRBrack: pk = KIND_RBRACKET;
          ChComma:  pk = KIND_COMMA;
          default: begin
            pk    = KIND_EOF;
            punct = 1'b0;
          end
        endcase
        if (punct) emit(pk, c, 1'b1, 1'b1, ERR_NONE);
        else fault(ERR_BAD_CHAR);
      end
    endfunction

    function void take_byte(logic [7:0] c);
      kind_e ik;
      bytes_taken++;
      step_beats.delete();
      if (halted) return;
      case (mode)
        MODE_IDENT: begin
          if (is_letter(c)) begin
            grow_ident(c);
            emit(KIND_EOF, c, 1'b1, 1'b0, ERR_NONE);
          end else begin
            if (ident_len == 3 && ident_head[23:0] == "end") ik = KIND_END;
            else if (ident_len == 5 && ident_head == "False") ik = KIND_FALSE;
            else if (ident_len == 4 && ident_head[31:0] == "True") ik = KIND_TRUE;
            else ik = KIND_IDENT;
            emit(ik, 8'h00, 1'b0, 1'b1, ERR_NONE);
            lex_idle(c);
          end
        end
        MODE_INT: begin
          if (is_digit(c)) begin
            emit(KIND_EOF, c, 1'b1, 1'b0, ERR_NONE);
          end else if (c == ChDot) begin
            mode = MODE_FRAC;
            emit(KIND_EOF, c, 1'b1, 1'b0, ERR_NONE);
          end else begin
            emit(minus_seen ? KIND_SINT : KIND_UINT, 8'h00, 1'b0, 1'b1, ERR_NONE);
            minus_seen = 1'b0;
            lex_idle(c);
          end
        end
        MODE_FRAC: begin
          if (is_digit(c)) begin
            emit(KIND_EOF, c, 1'b1, 1'b0, ERR_NONE);
          end else begin
            emit(KIND_FLOAT, 8'h00, 1'b0, 1'b1, ERR_NONE);
            minus_seen = 1'b0;
            lex_idle(c);
          end
        end
        MODE_STR: begin
          if (c == ChQuote) begin
            emit(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
            mode = MODE_IDLE;
          end else if (c == ChNul) begin
            fault(ERR_UNTERM_STR);
          end else if (c == ChNl) begin
            fault(ERR_MULTILINE_STR);
          end else begin
            emit(KIND_EOF, c, 1'b1, 1'b0, ERR_NONE);
          end
        end
        MODE_CMT: begin
          // A NUL ends the comment and still yields the end-of-input token.
          if (c == ChNl) begin
            bump_line();
            mode = MODE_IDLE;
          end else if (c == ChNul) begin
            lex_idle(c);
          end
        end
        default: lex_idle(c);
      endcase
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
      foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
    endfunction

    function void check_beat(logic [31:0] data, logic [3:0] user, logic last);
      token_beat_t exp;
      if (expected_beats.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected beat: tdata=%h tuser=%0d tlast=%b",
                   $realtime, data, user, last);
        mismatches++;
        return;
      end
      exp = expected_beats.pop_front();
      if (user !== exp.kind || data[7:0] !== exp.text_byte ||
          data[8] !== exp.text_valid || data[9] !== exp.token_done ||
          data[25:10] !== exp.line_no || data[27:26] !== exp.error_code ||
          data[31:28] !== 4'h0 || last !== exp.last) begin
        if (mismatches < 10) begin
          $display("[%0t] beat mismatch (exp/act): kind %0d/%0d text %h/%h tv %b/%b",
                   $realtime, exp.kind, user, exp.text_byte, data[7:0],
                   exp.text_valid, data[8]);
          $display("  done %b/%b line %0d/%0d err %0d/%0d last %b/%b pad 0/%h",
                   exp.token_done, data[9], exp.line_no, data[25:10],
                   exp.error_code, data[27:26], exp.last, last, data[31:28]);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  token_scoreboard sb;
  logic [7:0]      src_q[$];
  int unsigned     directed_len;
  int unsigned     idle_cycles = 0;

  markup_lexer_byte_tokenizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void put_src(logic [7:0] b);
    src_q.insert(src_q.size(), b);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) put_src(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    case ($urandom_range(2))
      0:       return 8'("a" + $urandom_range(25));
      1:       return 8'("A" + $urandom_range(25));
      default: return ChUscore;
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(4))
      0:       return ChTab;
      1:       return ChNl;
      2:       return ChCr;
      3:       return ChFf;
      default: return ChSpace;
    endcase
  endfunction

  // One well-formed token (or harmless filler) with random content.
  function automatic void add_token();
    string      words[10] = '{"end", "False", "True", "en", "Fals", "Truex", "ends",
                              "false", "TRUE", "_end"};
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 22) begin
      if ($urandom_range(3) == 0) begin
        push_text(words[$urandom_range(9)]);
      end else begin
        n = $urandom_range(10, 1);
        repeat (n) put_src(rand_letter());
      end
    end else if (pick < 42) begin
      // A number glued to a preceding fraction would read as a second dot.
      if (src_q.size() > 0 &&
          (src_q[$] == ChDot || (src_q[$] >= "0" && src_q[$] <= "9")))
        put_src(ChSpace);
      // Optional sign, digits, optional fraction; a bare minus closes as a signed token.
      n = 1;
      if ($urandom_range(9) < 3) begin
        put_src(ChMinus);
        n = 0;
      end
      repeat ($urandom_range(5, n)) put_src(8'("0" + $urandom_range(9)));
      if ($urandom_range(9) < 4) begin
        put_src(ChDot);
        repeat ($urandom_range(4)) put_src(8'("0" + $urandom_range(9)));
      end
    end else if (pick < 57) begin
      put_src(ChQuote);
      repeat ($urandom_range(8)) begin
        do b = 8'($urandom_range(255, 1)); while (b == ChQuote || b == ChNl);
        put_src(b);
      end
      put_src(ChQuote);
    end else if (pick < 65) begin
      put_src(ChHash);
      repeat ($urandom_range(8)) begin
        do b = 8'($urandom_range(255, 1)); while (b == ChNl);
        put_src(b);
      end
      put_src(($urandom_range(9) == 0) ? ChNul : ChNl);
    end else if (pick < 85) begin
      case ($urandom_range(4))
        0:       put_src(ChEqual);
        1:       put_src(ChColon);
        2:       put_src(ChLBrack);
        3:       put_src(ChRBrack);
        default: put_src(ChComma);
      endcase
    end else if (pick < 90) begin
      put_src(ChNul);
    end else begin
      // Any byte that idle mode takes without opening a string or comment.
      do b = 8'($urandom_range(255));
      while (!((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9") ||
               b == ChUscore || b == ChMinus || b == ChNul || b == ChSpace || b == ChTab ||
               b == ChNl || b == ChCr || b == ChFf || b == ChEqual || b == ChColon ||
               b == ChLBrack || b == ChRBrack || b == ChComma));
      put_src(b);
    end
    if ($urandom_range(9) < 6) put_src(rand_blank());
  endfunction

  function automatic void build_stimulus();
    logic [7:0] b;
    push_text("end False=True:[-7.5,-]");
    push_text("#x");
    put_src(ChNul);
    directed_len = src_q.size();
    while (src_q.size() < directed_len + RandomBytes) add_token();
    // Any error halts the block for good, so exactly one closes the run.
    put_src(ChSpace);
    case ($urandom_range(3))
      0: begin
        if ($urandom_range(1) == 0) put_src(rand_letter());
        case ($urandom_range(3))
          0:       b = 8'h0B;
          1:       b = ChDot;
          2:       b = 8'($urandom_range(255, 128));
          default: b = "$";
        endcase
        put_src(b);
      end
      1: push_text("3.1.");
      2: begin
        push_text("\"ab");
        put_src(ChNul);
      end
      default: begin
        push_text("\"ab");
        put_src(ChNl);
      end
    endcase
    repeat (8) put_src(8'($urandom_range(255)));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.take_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin : sink
    int n;
    int burst;
    bit hold_done;
    burst     = 0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      // One long hold-off lets the result queue fill and back-pressure the input.
      if (!hold_done && sb.bytes_taken >= HoldAfter) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      n = 0;
      if (burst > 0) burst--;
      else if ($urandom_range(39) == 0) burst = $urandom_range(80, 30);
      else n = pick_gap();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : source
    int gap;
    int burst;
    sb    = new();
    burst = 0;
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned idx = 0; idx < src_q.size(); idx++) begin
      gap = 0;
      if (idx == directed_len) begin
        // Let the block drain completely before the random traffic starts.
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (sb.expected_beats.size() != 0);
      end else begin
        if (burst > 0) burst--;
        else if ($urandom_range(39) == 0) burst = $urandom_range(80, 30);
        else gap = pick_gap();
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      send_byte(src_q[idx]);
    end
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_beats.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
